@@ src/brb_pkg.sv @@
// Shared types and constants for the byte ring buffer engine.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package brb_pkg;

    localparam int CMD_W  = 4;
    localparam int CNT_W  = 11;
    localparam int OFF_W  = 10;
    localparam int BYTE_W = 8;
    localparam int ST_W   = 3;

    // largest value the capacity register can hold
    localparam int CNT_MAX = (1 << CNT_W) - 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_START  = 4'd0,
        CMD_WRITE_BYTE   = 4'd1,
        CMD_READ_START   = 4'd2,
        CMD_PEEK_START   = 4'd3,
        CMD_NEXT_BYTE    = 4'd4,
        CMD_CLEAR        = 4'd5,
        CMD_COMMIT_WRITE = 4'd6,
        CMD_COMMIT_READ  = 4'd7,
        CMD_LINEAR_WRITE = 4'd8,
        CMD_LINEAR_READ  = 4'd9
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK         = 3'd0,
        ST_ZERO_LEN   = 3'd1,
        ST_NO_ROOM    = 3'd2,
        ST_BAD_COMMIT = 3'd3,
        ST_SEQ_ERR    = 3'd4
    } status_t;

    // open burst, one-hot
    typedef enum logic [3:0] {
        KIND_NONE  = 4'b0001,
        KIND_WRITE = 4'b0010,
        KIND_READ  = 4'b0100,
        KIND_PEEK  = 4'b1000
    } kind_t;

endpackage

@@ src/brb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/byte_ring_buffer_engine.sv @@
// Byte ring buffer engine top level: command decode, pointer state, output register.
// Depends on brb_pkg and brb_ram.
`timescale 1ns / 1ps

// Circular byte FIFO. Every item produces exactly one result item. An item is
// taken whenever the output register is empty or being drained in the same
// cycle, so the block streams one item per clock, next_byte included: the
// byte store is a single RAM with one write and one registered read port, a
// write_byte writes it in the accept cycle and a next_byte launches its read
// in the accept cycle, the byte appearing on data_out together with the rest
// of the result in the next cycle. The read data register only changes when a
// new next_byte is accepted, so a stalled result holds its byte. Writing
// capacity (always ready) empties the buffer at once and drops any open
// burst; the byte store itself is never cleared, there is no clearing pass.
// Capacity 0 acts as 1, values above DEPTH act as DEPTH. A data item
// outside its burst returns a sequence error and drops the open burst; any
// other known command also drops an open burst, which then commits nothing.

module byte_ring_buffer_engine
    import brb_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration: capacity register
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data,
    // command items
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  command,
    input  logic [CNT_W-1:0]  count,
    input  logic [BYTE_W-1:0] data_byte,
    // result items
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ST_W-1:0]   status,
    output logic [CNT_W-1:0]  count_out,
    output logic [OFF_W-1:0]  offset,
    output logic [BYTE_W-1:0] data_out,
    output logic              last
);

    localparam int PW = $clog2(DEPTH);
    // sum width for pointer plus count
    localparam int SW = ((PW > CNT_W) ? PW : CNT_W) + 1;
    localparam logic [CNT_W-1:0] CAP_MAX =
        (DEPTH > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(DEPTH);

    // state
    logic [CNT_W-1:0] capacity_reg;
    logic [PW-1:0]    rd_ptr_reg,  rd_ptr_next;
    logic [PW-1:0]    wr_ptr_reg,  wr_ptr_next;
    logic [CNT_W-1:0] fill_reg,    fill_next;
    logic [PW-1:0]    bptr_reg,    bptr_next;
    logic [CNT_W-1:0] brem_reg,    brem_next;
    logic [CNT_W-1:0] blen_reg,    blen_next;
    kind_t            kind_reg,    kind_next;

    // output register
    logic             out_valid_reg;
    logic             out_rd_reg;
    logic [ST_W-1:0]  status_reg;
    logic [CNT_W-1:0] count_out_reg;
    logic [OFF_W-1:0] offset_reg;
    logic             last_reg;

    // per-item results
    status_t          st;
    logic [CNT_W-1:0] cout;
    logic [OFF_W-1:0] off;
    logic             lst;
    logic             mem_we;
    logic             mem_re;

    logic             in_fire;
    logic             cfg_fire;
    logic [CNT_W-1:0] cap;
    logic [CNT_W-1:0] room;
    logic             cmd_known;
    logic             own;
    logic [CNT_W-1:0] avail;
    logic [PW-1:0]    bptr_inc;
    logic [CNT_W-1:0] lin_w;
    logic [CNT_W-1:0] lin_r;
    logic [BYTE_W-1:0] ram_rdata;

    // wrap p + n into 0..cap-1; n <= cap and p < cap keep it to one subtract
    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p,
                                               input logic [CNT_W-1:0] n,
                                               input logic [CNT_W-1:0] c);
        logic [SW-1:0] s;
        s = SW'(p) + SW'(n);
        if (s >= SW'(c))
        begin
            s = s - SW'(c);
        end
        return PW'(s);
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    assign cap = (capacity_reg == '0) ? CNT_W'(1)
               : ((capacity_reg > CAP_MAX) ? CAP_MAX : capacity_reg);
    assign room = cap - fill_reg;

    assign cmd_known = (command <= CMD_LINEAR_READ);
    assign own = ((command == CMD_WRITE_BYTE) && (kind_reg == KIND_WRITE))
              || ((command == CMD_NEXT_BYTE)
                  && ((kind_reg == KIND_READ) || (kind_reg == KIND_PEEK)));

    assign avail = (command == CMD_WRITE_START) ? room : fill_reg;
    assign bptr_inc = ((SW'(bptr_reg) + SW'(1)) == SW'(cap)) ? '0 : PW'(bptr_reg + 1'b1);

    // linear space up to the wrap point
    assign lin_w = (room < CNT_W'(SW'(cap) - SW'(wr_ptr_reg)))
                 ? room : CNT_W'(SW'(cap) - SW'(wr_ptr_reg));
    assign lin_r = (fill_reg < CNT_W'(SW'(cap) - SW'(rd_ptr_reg)))
                 ? fill_reg : CNT_W'(SW'(cap) - SW'(rd_ptr_reg));

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        bptr_next   = bptr_reg;
        brem_next   = brem_reg;
        blen_next   = blen_reg;
        kind_next   = kind_reg;
        st          = ST_OK;
        cout        = '0;
        off         = '0;
        lst         = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;

        if (in_fire && cmd_known)
        begin
            // any foreign command drops the open burst
            if (!own && (kind_reg != KIND_NONE))
            begin
                kind_next = KIND_NONE;
                brem_next = '0;
                blen_next = '0;
            end

            case (cmd_t'(command))
                CMD_WRITE_START, CMD_READ_START, CMD_PEEK_START:
                begin
                    if (count == '0)
                    begin
                        st = ST_ZERO_LEN;
                    end
                    else if (count > avail)
                    begin
                        st = ST_NO_ROOM;
                    end
                    else
                    begin
                        if (command == CMD_WRITE_START)
                        begin
                            kind_next = KIND_WRITE;
                            bptr_next = wr_ptr_reg;
                        end
                        else
                        begin
                            kind_next = (command == CMD_READ_START) ? KIND_READ : KIND_PEEK;
                            bptr_next = rd_ptr_reg;
                        end
                        brem_next = count;
                        blen_next = count;
                        cout      = count;
                    end
                end
                CMD_WRITE_BYTE, CMD_NEXT_BYTE:
                begin
                    if (!own || (brem_reg == '0))
                    begin
                        st        = ST_SEQ_ERR;
                        kind_next = KIND_NONE;
                        brem_next = '0;
                        blen_next = '0;
                    end
                    else
                    begin
                        mem_we    = (command == CMD_WRITE_BYTE);
                        mem_re    = (command == CMD_NEXT_BYTE);
                        bptr_next = bptr_inc;
                        brem_next = brem_reg - 1'b1;
                        cout      = brem_reg - 1'b1;
                        if (brem_reg == CNT_W'(1))
                        begin
                            lst = 1'b1;
                            if (kind_reg == KIND_WRITE)
                            begin
                                wr_ptr_next = bptr_inc;
                                fill_next   = fill_reg + blen_reg;
                            end
                            else if (kind_reg == KIND_READ)
                            begin
                                rd_ptr_next = bptr_inc;
                                fill_next   = fill_reg - blen_reg;
                            end
                            kind_next = KIND_NONE;
                            blen_next = '0;
                        end
                    end
                end
                CMD_CLEAR:
                begin
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                    fill_next   = '0;
                    bptr_next   = '0;
                    brem_next   = '0;
                    blen_next   = '0;
                    kind_next   = KIND_NONE;
                end
                CMD_COMMIT_WRITE:
                begin
                    if (count > room)
                    begin
                        st = ST_BAD_COMMIT;
                    end
                    else
                    begin
                        wr_ptr_next = wrap_add(wr_ptr_reg, count, cap);
                        fill_next   = fill_reg + count;
                        cout        = count;
                    end
                end
                CMD_COMMIT_READ:
                begin
                    if (count > fill_reg)
                    begin
                        st = ST_BAD_COMMIT;
                    end
                    else
                    begin
                        rd_ptr_next = wrap_add(rd_ptr_reg, count, cap);
                        fill_next   = fill_reg - count;
                        cout        = count;
                    end
                end
                CMD_LINEAR_WRITE:
                begin
                    cout = lin_w;
                    off  = OFF_W'(wr_ptr_reg);
                end
                CMD_LINEAR_READ:
                begin
                    cout = lin_r;
                    off  = OFF_W'(rd_ptr_reg);
                end
                default:
                begin
                    cout = '0;
                end
            endcase
        end

        // capacity write empties everything
        if (cfg_fire)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            fill_next   = '0;
            bptr_next   = '0;
            brem_next   = '0;
            blen_next   = '0;
            kind_next   = KIND_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_MAX;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            bptr_reg      <= '0;
            brem_reg      <= '0;
            blen_reg      <= '0;
            kind_reg      <= KIND_NONE;
            out_valid_reg <= 1'b0;
            out_rd_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                capacity_reg <= cfg_data;
            end
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
            bptr_reg   <= bptr_next;
            brem_reg   <= brem_next;
            blen_reg   <= blen_next;
            kind_reg   <= kind_next;
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
                out_rd_reg    <= mem_re;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg    <= st;
            count_out_reg <= cout;
            offset_reg    <= off;
            last_reg      <= lst;
        end
    end

    brb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (in_fire && mem_we),
        .waddr (bptr_reg),
        .wdata (data_byte),
        .re    (in_fire && mem_re),
        .raddr (bptr_reg),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign count_out = count_out_reg;
    assign offset    = offset_reg;
    assign last      = last_reg;
    assign data_out  = out_rd_reg ? ram_rdata : '0;

`ifndef SYNTHESIS
    a_fill_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= cap)
        else $error("fill level above capacity");

    a_ptrs_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(rd_ptr_reg) < cap) && (CNT_W'(wr_ptr_reg) < cap))
        else $error("pointer outside active slots");

    a_idle_no_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (kind_reg == KIND_NONE) |-> ((brem_reg == '0) && (blen_reg == '0)))
        else $error("remaining count with no open burst");

    a_burst_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (kind_reg != KIND_NONE) |-> ((brem_reg != '0) && (brem_reg <= blen_reg)))
        else $error("burst remaining count inconsistent");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && lst) |=> (kind_reg == KIND_NONE) && out_valid && last
                             && (count_out == '0))
        else $error("final byte did not close the burst");
`endif

endmodule
